@@ design/ffe_pkg.sv @@
// ffe_pkg: shared types, codes and constants of the flood fill engine
// depends on nothing; used by every other file of the block
package ffe_pkg;

  // default frame size and field widths
  localparam int DEF_FRAME_WIDTH  = 256;
  localparam int DEF_FRAME_HEIGHT = 256;
  localparam int DEF_ADDR_W       = 16;
  localparam int COLOR_W          = 24;
  localparam int COORD_W          = 9;

  localparam logic [COLOR_W-1:0] WHITE = 24'hFF_FFFF;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUT_FRAME = 2'd1;
  localparam logic [1:0] ST_SEED_DIFF = 2'd2;
  localparam logic [1:0] ST_SAME_FILL = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COLOR_W-1:0] target_color;
    logic [COLOR_W-1:0] pixel_color;
  } ffe_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [1:0]         status;
  } ffe_res_t;

  // bits needed for a coordinate below n, at least one
  function automatic int coord_bits(input int n);
    int w;
    w = $clog2(n);
    return (w < 1) ? 1 : w;
  endfunction

endpackage

@@ design/ffe_ram.sv @@
// ffe_ram: simple dual port synchronous memory, one write and one read port
// read data registered; depends on ffe_pkg for defaults
module ffe_ram #(
  parameter int ADDR_W = ffe_pkg::DEF_ADDR_W,
  parameter int DATA_W = ffe_pkg::COLOR_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/ffe_fill_ctrl.sv @@
// ffe_fill_ctrl: request sequencer, frame clear pass and flood fill walker
// drives the frame memory and the pending stack memory; depends on ffe_pkg
module ffe_fill_ctrl #(
  parameter int FRAME_WIDTH  = ffe_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = ffe_pkg::DEF_FRAME_HEIGHT,
  parameter int XW = ffe_pkg::coord_bits(FRAME_WIDTH),
  parameter int YW = ffe_pkg::coord_bits(FRAME_HEIGHT),
  parameter int AW = XW + YW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ffe_pkg::ffe_req_t           req,
  output logic                        busy,
  input  logic                        conn_mode,
  output logic                        res_valid,
  output ffe_pkg::ffe_res_t           res,
  // frame memory
  output logic                        fr_we,
  output logic [AW-1:0]               fr_waddr,
  output logic [ffe_pkg::COLOR_W-1:0] fr_wdata,
  output logic [AW-1:0]               fr_raddr,
  input  logic [ffe_pkg::COLOR_W-1:0] fr_rdata,
  // pending stack memory
  output logic                        st_we,
  output logic [AW-1:0]               st_waddr,
  output logic [AW-1:0]               st_wdata,
  output logic [AW-1:0]               st_raddr,
  input  logic [AW-1:0]               st_rdata
);

  localparam int SPW = AW + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_POP   = 7'b0001000,
    S_CTR   = 7'b0010000,
    S_NBR   = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [SPW-1:0]              sp_r, sp_nxt;
  logic [XW-1:0]               cx_r, cx_nxt;
  logic [YW-1:0]               cy_r, cy_nxt;
  logic [2:0]                  k_r, k_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               paddr_r, paddr_nxt;
  logic [ffe_pkg::COLOR_W-1:0] target_r, target_nxt;
  logic [ffe_pkg::COLOR_W-1:0] fill_r, fill_nxt;
  logic                        is_fill_r, is_fill_nxt;
  logic                        res_valid_r, res_valid_nxt;
  ffe_pkg::ffe_res_t           res_r, res_nxt;

  logic                        in_frame;
  logic [AW-1:0]               seed_addr;
  logic [1:0]                  dx, dy;
  logic                        nbr_ok;
  logic [XW-1:0]               nx;
  logic [YW-1:0]               ny;
  logic                        hit;
  logic [SPW-1:0]              sp_dec;
  logic [2:0]                  k_last;

  // neighbor offsets: the four orthogonal steps first, then the diagonals
  function automatic logic [3:0] nbr_offset(input logic [2:0] k);
    logic [3:0] o;
    case (k)
      3'd0:    o = {2'b11, 2'b00};
      3'd1:    o = {2'b00, 2'b11};
      3'd2:    o = {2'b00, 2'b01};
      3'd3:    o = {2'b01, 2'b00};
      3'd4:    o = {2'b11, 2'b11};
      3'd5:    o = {2'b11, 2'b01};
      3'd6:    o = {2'b01, 2'b11};
      default: o = {2'b01, 2'b01};
    endcase
    return o;
  endfunction

  // seed position check and address
  assign in_frame = ({1'b0, req.x_coord} < 10'(FRAME_WIDTH)) &&
                    ({1'b0, req.y_coord} < 10'(FRAME_HEIGHT));
  assign seed_addr = {req.y_coord[YW-1:0], req.x_coord[XW-1:0]};

  // neighbor coordinate for the current step, with frame edge check
  always_comb begin
    {dy, dx} = nbr_offset(k_r);
    nbr_ok = 1'b1;
    case (dx)
      2'b11: begin
        nbr_ok = nbr_ok && (cx_r != '0);
        nx = cx_r - 1'b1;
      end
      2'b01: begin
        nbr_ok = nbr_ok && (cx_r != XW'(FRAME_WIDTH - 1));
        nx = cx_r + 1'b1;
      end
      default: nx = cx_r;
    endcase
    case (dy)
      2'b11: begin
        nbr_ok = nbr_ok && (cy_r != '0);
        ny = cy_r - 1'b1;
      end
      2'b01: begin
        nbr_ok = nbr_ok && (cy_r != YW'(FRAME_HEIGHT - 1));
        ny = cy_r + 1'b1;
      end
      default: ny = cy_r;
    endcase
  end

  assign hit    = pend_r && (fr_rdata == target_r);
  assign sp_dec = sp_r - 1'b1;
  assign k_last = conn_mode ? 3'd7 : 3'd3;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    sp_nxt        = sp_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    target_nxt    = target_r;
    fill_nxt      = fill_r;
    is_fill_nxt   = is_fill_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    fr_we         = 1'b0;
    fr_waddr      = paddr_r;
    fr_wdata      = fill_r;
    fr_raddr      = paddr_r;
    st_we         = 1'b0;
    st_waddr      = sp_r[AW-1:0];
    st_wdata      = paddr_r;
    st_raddr      = sp_dec[AW-1:0];

    case (state_r)
      // write white over the whole frame after reset
      S_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = clr_r;
        fr_wdata = ffe_pkg::WHITE;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (start) begin
          res_nxt.read_color = '0;
          res_nxt.status     = ffe_pkg::ST_OK;
          paddr_nxt          = seed_addr;
          target_nxt         = req.target_color;
          fill_nxt           = req.pixel_color;
          case (req.req_type)
            ffe_pkg::REQ_WRITE: begin
              res_valid_nxt = 1'b1;
              if (in_frame) begin
                fr_we    = 1'b1;
                fr_waddr = seed_addr;
                fr_wdata = req.pixel_color;
              end else begin
                res_nxt.status = ffe_pkg::ST_OUT_FRAME;
              end
            end
            ffe_pkg::REQ_READ, ffe_pkg::REQ_FILL: begin
              if (in_frame) begin
                fr_raddr    = seed_addr;
                is_fill_nxt = (req.req_type == ffe_pkg::REQ_FILL);
                state_nxt   = S_LOOK;
              end else begin
                res_valid_nxt  = 1'b1;
                res_nxt.status = ffe_pkg::ST_OUT_FRAME;
              end
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // seed pixel data is back: finish a read or check a fill
      S_LOOK: begin
        if (!is_fill_r) begin
          res_valid_nxt      = 1'b1;
          res_nxt.read_color = fr_rdata;
          state_nxt          = S_IDLE;
        end else if (fr_rdata != target_r) begin
          res_valid_nxt  = 1'b1;
          res_nxt.status = ffe_pkg::ST_SEED_DIFF;
          state_nxt      = S_IDLE;
        end else if (target_r == fill_r) begin
          res_valid_nxt  = 1'b1;
          res_nxt.status = ffe_pkg::ST_SAME_FILL;
          state_nxt      = S_IDLE;
        end else begin
          // recolor the seed and push it
          fr_we     = 1'b1;
          st_we     = 1'b1;
          sp_nxt    = sp_r + 1'b1;
          state_nxt = S_POP;
        end
      end

      // read the top of the pending stack
      S_POP: begin
        sp_nxt    = sp_dec;
        state_nxt = S_CTR;
      end

      // latch the center pixel
      S_CTR: begin
        cx_nxt    = st_rdata[XW-1:0];
        cy_nxt    = st_rdata[AW-1:XW];
        k_nxt     = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_NBR;
      end

      // one neighbor read per cycle, previous neighbor checked meanwhile
      S_NBR: begin
        if (hit) begin
          fr_we  = 1'b1;
          st_we  = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        fr_raddr  = {ny, nx};
        paddr_nxt = {ny, nx};
        pend_nxt  = nbr_ok;
        if (k_r == k_last) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // check the last neighbor, then next center or done
      S_DRAIN: begin
        pend_nxt = 1'b0;
        if (hit) begin
          fr_we  = 1'b1;
          st_we  = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        if (hit || (sp_r != '0)) begin
          state_nxt = S_POP;
        end else begin
          res_valid_nxt      = 1'b1;
          res_nxt.read_color = '0;
          res_nxt.status     = ffe_pkg::ST_OK;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      is_fill_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      is_fill_r   <= is_fill_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    paddr_r  <= paddr_nxt;
    target_r <= target_nxt;
    fill_r   <= fill_nxt;
    res_r    <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ design/flood_fill_engine.sv @@
// Flood fill engine over a FRAME_WIDTH x FRAME_HEIGHT frame of RGB 8:8:8 pixels held in a
// synchronous frame memory, with a pending stack memory for fills. After reset the block
// holds busy high for a clear pass while it writes white over the whole frame memory. A
// write, an out-of-frame request or an unused request code gives its result in the cycle
// after it is taken, and the next request may be taken while that result shows; a read
// or a fill that ends at the seed check gives its result once the seed pixel read is
// checked in S_LOOK. A fill visits each recolored pixel through S_POP, S_CTR, one S_NBR
// step per neighbor (4 or 8 by connectivity) and S_DRAIN, paced by the single read
// port of the frame memory, which checks one neighbor per cycle. Each result shows on
// out_result for exactly one cycle with out_valid high; the receiver cannot stall it.
// Depends on ffe_pkg, ffe_ram and ffe_fill_ctrl.
module flood_fill_engine #(
  parameter int FRAME_WIDTH  = ffe_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = ffe_pkg::DEF_FRAME_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  ffe_pkg::ffe_req_t in_req,
  // result channel
  output logic              out_valid,
  output ffe_pkg::ffe_res_t out_result,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int XW = ffe_pkg::coord_bits(FRAME_WIDTH);
  localparam int YW = ffe_pkg::coord_bits(FRAME_HEIGHT);
  localparam int AW = XW + YW;

  logic                        conn_mode_r;
  logic                        fr_we;
  logic [AW-1:0]               fr_waddr;
  logic [ffe_pkg::COLOR_W-1:0] fr_wdata;
  logic [AW-1:0]               fr_raddr;
  logic [ffe_pkg::COLOR_W-1:0] fr_rdata;
  logic                        st_we;
  logic [AW-1:0]               st_waddr;
  logic [AW-1:0]               st_wdata;
  logic [AW-1:0]               st_raddr;
  logic [AW-1:0]               st_rdata;

  // connectivity register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      conn_mode_r <= cfg_data;
    end
  end

  // sequencer
  ffe_fill_ctrl #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .XW           (XW),
    .YW           (YW),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_req),
    .busy      (busy),
    .conn_mode (conn_mode_r),
    .res_valid (out_valid),
    .res       (out_result),
    .fr_we     (fr_we),
    .fr_waddr  (fr_waddr),
    .fr_wdata  (fr_wdata),
    .fr_raddr  (fr_raddr),
    .fr_rdata  (fr_rdata),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata)
  );

  // frame store
  ffe_ram #(
    .ADDR_W (AW),
    .DATA_W (ffe_pkg::COLOR_W)
  ) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // pending stack of pixel addresses
  ffe_ram #(
    .ADDR_W (AW),
    .DATA_W (AW)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule
